FILE: hw/rtl/bmd_pkg.sv
// Package for the Bezier maximum-deviation block: field widths, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package bmd_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int DEV_WIDTH   = 25;
   localparam int DEV_FRAC    = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_KSTART,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_LV_RD0,
      ST_LV_LDA,
      ST_LV_RD,
      ST_LV_DIFF,
      ST_LV_MUL,
      ST_LV_WR,
      ST_EV_RD,
      ST_EV_ABS,
      ST_EV_CMP,
      ST_FIN_RD,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic busy;
      logic load_pt;
      logic seg_start;
      logic div_step;
      logic k_start;
      logic copy_rd;
      logic copy_wr;
      logic lv_rd0;
      logic lv_lda;
      logic lv_rd;
      logic lv_diff;
      logic lv_mul;
      logic lv_wr;
      logic ev_rd;
      logic ev_abs;
      logic ev_cmp;
      logic fin_rd;
      logic fin_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic copy_last;
      logic j_last;
      logic lvl_last;
      logic n_one;
      logic k_last;
   } sts_type;

endpackage

FILE: hw/rtl/bezier_max_deviation.sv
// Top level of the Bezier maximum-deviation block: controller, datapath and
// response register. Depends on bmd_pkg, bmd_ctrl and bmd_dpath.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_x_coord, req_y_coord,
//                                                req_point_id, req_last_point
//   rsp_      out        rsp_valid / rsp_stall   rsp_max_point_id, rsp_deviation
//
// A request with the last mark closes a run of n points and starts its
// evaluation, which ends with any wait on the response slot. The single
// interpolation unit per axis runs each de Casteljau step as read,
// difference, multiply and write back; the first step of each level first
// reads and loads its left operand.
// Reset is synchronous and clears the point count, the best match and the FSM.
// req_stall is high while a run is evaluated; a waiting response holds in the
// output register while new points load, and only the final hand-off waits on
// rsp_stall.
module bezier_max_deviation #(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   input  logic [15:0] req_point_id,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_max_point_id,
   output logic [24:0] rsp_deviation
);

   bmd_pkg::cmd_type cmd;
   bmd_pkg::sts_type sts;

   logic                            rsp_valid_ff;
   logic [bmd_pkg::ID_WIDTH-1:0]    rsp_id_ff;
   logic [bmd_pkg::DEV_WIDTH-1:0]   rsp_dev_ff;
   logic [bmd_pkg::ID_WIDTH-1:0]    res_point_id;
   logic [bmd_pkg::DEV_WIDTH-1:0]   res_deviation;
   logic                            out_free;

   // the output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   bmd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .out_free       (out_free),
      .sts            (sts),
      .cmd            (cmd)
   );

   bmd_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .req_point_id  (req_point_id),
      .res_point_id  (res_point_id),
      .res_deviation (res_deviation)
   );

   // hold the request side off while a run is evaluated
   assign req_stall = cmd.busy;

   // response register: load on hand-off, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_load) begin
         rsp_id_ff  <= res_point_id;
         rsp_dev_ff <= res_deviation;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_point_id = rsp_id_ff;
   assign rsp_deviation    = rsp_dev_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fin_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while still waiting");

   a_last_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_point) |=> req_stall)
      else $error("closing request did not start evaluation");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.fin_load) |=> !rsp_valid_ff)
      else $error("taken response was repeated");
`endif

endmodule

FILE: hw/rtl/bmd_ctrl.sv
// Controller state machine of the Bezier maximum-deviation block.
// Depends on bmd_pkg (state, command and status types).
module bmd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_point,
   input  logic             out_free,
   input  bmd_pkg::sts_type sts,
   output bmd_pkg::cmd_type cmd
);

   bmd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmd_pkg::ST_IDLE: begin
            if (req_valid && req_last_point) state_in = bmd_pkg::ST_DIV;
         end
         bmd_pkg::ST_DIV: begin
            if (sts.div_last) state_in = bmd_pkg::ST_KSTART;
         end
         bmd_pkg::ST_KSTART:  state_in = bmd_pkg::ST_COPY_RD;
         bmd_pkg::ST_COPY_RD: state_in = bmd_pkg::ST_COPY_WR;
         bmd_pkg::ST_COPY_WR: begin
            if (!sts.copy_last) state_in = bmd_pkg::ST_COPY_RD;
            else if (sts.n_one) state_in = bmd_pkg::ST_EV_RD;
            else state_in = bmd_pkg::ST_LV_RD0;
         end
         bmd_pkg::ST_LV_RD0:  state_in = bmd_pkg::ST_LV_LDA;
         bmd_pkg::ST_LV_LDA:  state_in = bmd_pkg::ST_LV_DIFF;
         bmd_pkg::ST_LV_RD:   state_in = bmd_pkg::ST_LV_DIFF;
         bmd_pkg::ST_LV_DIFF: state_in = bmd_pkg::ST_LV_MUL;
         bmd_pkg::ST_LV_MUL:  state_in = bmd_pkg::ST_LV_WR;
         bmd_pkg::ST_LV_WR: begin
            if (!sts.j_last) state_in = bmd_pkg::ST_LV_RD;
            else if (sts.lvl_last) state_in = bmd_pkg::ST_EV_RD;
            else state_in = bmd_pkg::ST_LV_RD0;
         end
         bmd_pkg::ST_EV_RD:   state_in = bmd_pkg::ST_EV_ABS;
         bmd_pkg::ST_EV_ABS:  state_in = bmd_pkg::ST_EV_CMP;
         bmd_pkg::ST_EV_CMP: begin
            if (sts.k_last) state_in = bmd_pkg::ST_FIN_RD;
            else state_in = bmd_pkg::ST_KSTART;
         end
         bmd_pkg::ST_FIN_RD:  state_in = bmd_pkg::ST_FIN;
         bmd_pkg::ST_FIN: begin
            if (out_free) state_in = bmd_pkg::ST_IDLE;
         end
         default: state_in = bmd_pkg::ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         bmd_pkg::ST_IDLE: begin
            cmd.load_pt   = req_valid;
            cmd.seg_start = req_valid && req_last_point;
         end
         bmd_pkg::ST_DIV: begin
            cmd.busy     = 1'b1;
            cmd.div_step = 1'b1;
         end
         bmd_pkg::ST_KSTART: begin
            cmd.busy    = 1'b1;
            cmd.k_start = 1'b1;
         end
         bmd_pkg::ST_COPY_RD: begin
            cmd.busy    = 1'b1;
            cmd.copy_rd = 1'b1;
         end
         bmd_pkg::ST_COPY_WR: begin
            cmd.busy    = 1'b1;
            cmd.copy_wr = 1'b1;
         end
         bmd_pkg::ST_LV_RD0: begin
            cmd.busy   = 1'b1;
            cmd.lv_rd0 = 1'b1;
         end
         bmd_pkg::ST_LV_LDA: begin
            cmd.busy   = 1'b1;
            cmd.lv_lda = 1'b1;
         end
         bmd_pkg::ST_LV_RD: begin
            cmd.busy  = 1'b1;
            cmd.lv_rd = 1'b1;
         end
         bmd_pkg::ST_LV_DIFF: begin
            cmd.busy    = 1'b1;
            cmd.lv_diff = 1'b1;
         end
         bmd_pkg::ST_LV_MUL: begin
            cmd.busy   = 1'b1;
            cmd.lv_mul = 1'b1;
         end
         bmd_pkg::ST_LV_WR: begin
            cmd.busy  = 1'b1;
            cmd.lv_wr = 1'b1;
         end
         bmd_pkg::ST_EV_RD: begin
            cmd.busy  = 1'b1;
            cmd.ev_rd = 1'b1;
         end
         bmd_pkg::ST_EV_ABS: begin
            cmd.busy   = 1'b1;
            cmd.ev_abs = 1'b1;
         end
         bmd_pkg::ST_EV_CMP: begin
            cmd.busy   = 1'b1;
            cmd.ev_cmp = 1'b1;
         end
         bmd_pkg::ST_FIN_RD: begin
            cmd.busy   = 1'b1;
            cmd.fin_rd = 1'b1;
         end
         bmd_pkg::ST_FIN: begin
            cmd.busy     = 1'b1;
            cmd.fin_load = out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: hw/rtl/bmd_dpath.sv
// Datapath of the Bezier maximum-deviation block: point and work memories,
// t divider, interpolation unit per axis, deviation compare.
// Depends on bmd_pkg (command/status types, field widths).
module bmd_dpath #(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  bmd_pkg::cmd_type cmd,
   output bmd_pkg::sts_type sts,
   input  logic [bmd_pkg::COORD_WIDTH-1:0] req_x_coord,
   input  logic [bmd_pkg::COORD_WIDTH-1:0] req_y_coord,
   input  logic [bmd_pkg::ID_WIDTH-1:0]    req_point_id,
   output logic [bmd_pkg::ID_WIDTH-1:0]    res_point_id,
   output logic [bmd_pkg::DEV_WIDTH-1:0]   res_deviation
);

   localparam int CWID = bmd_pkg::COORD_WIDTH;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int WW   = CWID + FRAC_BITS;
   localparam int DW   = WW + 1;
   localparam int TW   = FRAC_BITS + 1;
   localparam int LO   = DW / 2;
   localparam int HW   = DW - LO;
   localparam int PW   = DW + TW + 1;
   localparam int DCW  = $clog2(FRAC_BITS + 1);

   logic [CWID-1:0] px_mem [MAX_POINTS];
   logic [CWID-1:0] py_mem [MAX_POINTS];
   logic [bmd_pkg::ID_WIDTH-1:0] pid_mem [MAX_POINTS];
   logic [WW-1:0]   wx_mem [MAX_POINTS];
   logic [WW-1:0]   wy_mem [MAX_POINTS];

   logic [CW-1:0]  cnt_ff, n_ff, rem_ff, r_ff;
   logic [AW-1:0]  j_ff, jend_ff, k_ff, bidx_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic [TW-1:0]  q_ff, t_ff;
   logic [bmd_pkg::DEV_WIDTH-1:0] best_ff;

   logic [CWID-1:0] px_rd_ff, py_rd_ff;
   logic [bmd_pkg::ID_WIDTH-1:0] pid_rd_ff;
   logic [WW-1:0]   wx_rd_ff, wy_rd_ff;
   logic [WW-1:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic [DW-1:0]   dfx_ff, dfy_ff, absx_ff, absy_ff;
   logic [LO+TW-1:0] plox_ff, ploy_ff;
   logic signed [HW+TW:0] phix_ff, phiy_ff;

   logic [CW-1:0]  n_m1, cnt_inc, n_in;
   logic           cnt_room;
   logic [CW:0]    rem_sh, r_sum;
   logic           rem_ge, r_ge;
   logic [AW-1:0]  st_addr, w_rd_addr, j_nx;
   logic           st_rd, w_rd, w_wr;
   logic [WW-1:0]  wx_wdata, wy_wdata, resx, resy;
   logic [LO+TW-1:0] plox_in, ploy_in;
   logic signed [HW+TW:0] phix_in, phiy_in;
   logic signed [PW-1:0]  px_prod, py_prod, qx, qy;
   logic [DW-1:0]  dx, dy;
   logic [DW:0]    dev_sum;
   logic [bmd_pkg::DEV_WIDTH-1:0] dev;

   assign n_m1     = n_ff - CW'(1);
   assign cnt_room = cnt_ff < CW'(MAX_POINTS);
   assign cnt_inc  = cnt_ff + CW'(1);
   assign n_in     = cnt_room ? cnt_inc : cnt_ff;
   assign j_nx     = j_ff + AW'(1);

   assign sts.div_last  = div_cnt_ff == '0;
   assign sts.copy_last = CW'(j_ff) == n_m1;
   assign sts.j_last    = j_ff == jend_ff;
   assign sts.lvl_last  = jend_ff == '0;
   assign sts.n_one     = n_ff == CW'(1);
   assign sts.k_last    = CW'(k_ff) == n_m1;

   // point store: write on load, read for copy, evaluation and final id
   assign st_rd   = cmd.copy_rd || cmd.ev_rd || cmd.fin_rd;
   assign st_addr = cmd.copy_rd ? j_ff : (cmd.ev_rd ? k_ff : bidx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_pt && cnt_room) begin
         px_mem[cnt_ff[AW-1:0]]  <= req_x_coord;
         py_mem[cnt_ff[AW-1:0]]  <= req_y_coord;
         pid_mem[cnt_ff[AW-1:0]] <= req_point_id;
      end
      if (st_rd) begin
         px_rd_ff  <= px_mem[st_addr];
         py_rd_ff  <= py_mem[st_addr];
         pid_rd_ff <= pid_mem[st_addr];
      end
   end

   // work arrays
   assign w_rd      = cmd.lv_rd0 || cmd.lv_lda || cmd.lv_rd || cmd.ev_rd;
   assign w_rd_addr = (cmd.lv_rd0 || cmd.ev_rd) ? '0 : j_nx;
   assign w_wr      = cmd.copy_wr || cmd.lv_wr;
   assign wx_wdata  = cmd.copy_wr ? {px_rd_ff, {FRAC_BITS{1'b0}}} : resx;
   assign wy_wdata  = cmd.copy_wr ? {py_rd_ff, {FRAC_BITS{1'b0}}} : resy;

   always_ff @(posedge clock) begin
      if (w_wr) begin
         wx_mem[j_ff] <= wx_wdata;
         wy_mem[j_ff] <= wy_wdata;
      end
      if (w_rd) begin
         wx_rd_ff <= wx_mem[w_rd_addr];
         wy_rd_ff <= wy_mem[w_rd_addr];
      end
   end

   // restoring divide of 2^FRAC_BITS by n-1, one bit a cycle
   assign rem_sh = {rem_ff, div_cnt_ff == DCW'(FRAC_BITS)};
   assign rem_ge = rem_sh >= {1'b0, n_m1};
   // step t by quotient plus carried remainder
   assign r_sum  = {1'b0, r_ff} + {1'b0, rem_ff};
   assign r_ge   = r_sum >= {1'b0, n_m1};

   // interpolation: a + floor((b - a) * t / 2^FRAC_BITS)
   assign plox_in = (LO+TW)'(dfx_ff[LO-1:0]) * (LO+TW)'(t_ff);
   assign ploy_in = (LO+TW)'(dfy_ff[LO-1:0]) * (LO+TW)'(t_ff);
   assign phix_in = $signed(dfx_ff[DW-1:LO]) * $signed({1'b0, t_ff});
   assign phiy_in = $signed(dfy_ff[DW-1:LO]) * $signed({1'b0, t_ff});
   assign px_prod = (PW'(phix_ff) <<< LO) + PW'($signed({1'b0, plox_ff}));
   assign py_prod = (PW'(phiy_ff) <<< LO) + PW'($signed({1'b0, ploy_ff}));
   assign qx      = px_prod >>> FRAC_BITS;
   assign qy      = py_prod >>> FRAC_BITS;
   assign resx    = ax_ff + qx[WW-1:0];
   assign resy    = ay_ff + qy[WW-1:0];

   // L1 distance to control point k
   assign dx      = {wx_rd_ff[WW-1], wx_rd_ff}
                  - {px_rd_ff[CWID-1], px_rd_ff, {FRAC_BITS{1'b0}}};
   assign dy      = {wy_rd_ff[WW-1], wy_rd_ff}
                  - {py_rd_ff[CWID-1], py_rd_ff, {FRAC_BITS{1'b0}}};
   assign dev_sum = {1'b0, absx_ff} + {1'b0, absy_ff};
   assign dev     = dev_sum[FRAC_BITS-bmd_pkg::DEV_FRAC +: bmd_pkg::DEV_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         best_ff <= '0;
         bidx_ff <= '0;
      end else begin
         if (cmd.fin_load) begin
            cnt_ff <= '0;
         end else if (cmd.load_pt && cnt_room) begin
            cnt_ff <= cnt_inc;
         end
         if (cmd.seg_start) begin
            best_ff <= '0;
            bidx_ff <= '0;
         end else if (cmd.ev_cmp && dev > best_ff) begin
            best_ff <= dev;
            bidx_ff <= k_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seg_start) begin
         n_ff       <= n_in;
         rem_ff     <= '0;
         q_ff       <= '0;
         div_cnt_ff <= DCW'(FRAC_BITS);
         k_ff       <= '0;
         t_ff       <= '0;
         r_ff       <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= rem_ge ? CW'(rem_sh - {1'b0, n_m1}) : CW'(rem_sh);
         q_ff       <= {q_ff[TW-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end
      if (cmd.ev_cmp) begin
         k_ff <= k_ff + AW'(1);
         if (r_ge) begin
            r_ff <= CW'(r_sum - {1'b0, n_m1});
            t_ff <= t_ff + q_ff + TW'(1);
         end else begin
            r_ff <= CW'(r_sum);
            t_ff <= t_ff + q_ff;
         end
      end
      if (cmd.k_start) begin
         j_ff <= '0;
      end
      if (cmd.copy_wr) begin
         if (sts.copy_last) begin
            j_ff    <= '0;
            jend_ff <= AW'(n_ff - CW'(2));
         end else begin
            j_ff <= j_nx;
         end
      end
      if (cmd.lv_lda) begin
         ax_ff <= wx_rd_ff;
         ay_ff <= wy_rd_ff;
      end
      if (cmd.lv_diff) begin
         bx_ff  <= wx_rd_ff;
         by_ff  <= wy_rd_ff;
         dfx_ff <= {wx_rd_ff[WW-1], wx_rd_ff} - {ax_ff[WW-1], ax_ff};
         dfy_ff <= {wy_rd_ff[WW-1], wy_rd_ff} - {ay_ff[WW-1], ay_ff};
      end
      if (cmd.lv_mul) begin
         plox_ff <= plox_in;
         ploy_ff <= ploy_in;
         phix_ff <= phix_in;
         phiy_ff <= phiy_in;
      end
      if (cmd.lv_wr) begin
         // old work[j+1] is the left operand of the next step
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
         if (sts.j_last) begin
            j_ff    <= '0;
            jend_ff <= jend_ff - AW'(1);
         end else begin
            j_ff <= j_nx;
         end
      end
      if (cmd.ev_abs) begin
         absx_ff <= dx[DW-1] ? (~dx + DW'(1)) : dx;
         absy_ff <= dy[DW-1] ? (~dy + DW'(1)) : dy;
      end
   end

   assign res_point_id  = pid_rd_ff;
   assign res_deviation = best_ff;

endmodule

FILE: verif/bezier_max_deviation_checker.sv
// Checker for the Bezier maximum-deviation block: watches both channels,
// predicts each run's result and compares it. Depends on bmd_pkg widths.
`timescale 1ns / 1ps

module bezier_max_deviation_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [bmd_pkg::COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [bmd_pkg::COORD_WIDTH-1:0] req_y_coord,
   input  logic [bmd_pkg::ID_WIDTH-1:0]  req_point_id,
   input  logic                       req_last_point,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [bmd_pkg::ID_WIDTH-1:0]  rsp_max_point_id,
   input  logic [bmd_pkg::DEV_WIDTH-1:0] rsp_deviation,
   output int                         errors,
   output int                         pending
);

   localparam int POINT_SLOTS = 64;
   localparam int FRAC        = 16;
   localparam int RING_DEPTH  = 8;

   typedef struct packed {
      logic [bmd_pkg::ID_WIDTH-1:0]  id;
      logic [bmd_pkg::DEV_WIDTH-1:0] dev;
   } match_type;

   logic signed [bmd_pkg::COORD_WIDTH-1:0] seg_x [POINT_SLOTS];
   logic signed [bmd_pkg::COORD_WIDTH-1:0] seg_y [POINT_SLOTS];
   logic [bmd_pkg::ID_WIDTH-1:0]           seg_id [POINT_SLOTS];
   int                            seg_count;
   match_type                     expected_ring [RING_DEPTH];
   int                            wr_count;
   int                            rd_count;

   function automatic longint interp(longint a, longint b, longint t);
      longint p;
      p = (b - a) * t;
      return a + (p >>> FRAC);
   endfunction

   // Evaluate the curve at each knot and keep the first strict maximum.
   function automatic match_type farthest_point(int n);
      longint wx [POINT_SLOTS];
      longint wy [POINT_SLOTS];
      longint t, dx, dy;
      logic [bmd_pkg::DEV_WIDTH-1:0] dv, best_dev;
      int best_k;
      match_type m;
      best_dev = '0;
      best_k = 0;
      for (int k = 0; k < n; k++) begin
         t = (n > 1) ? ((longint'(k) << FRAC) / (n - 1)) : 0;
         for (int j = 0; j < n; j++) begin
            wx[j] = longint'(seg_x[j]) <<< FRAC;
            wy[j] = longint'(seg_y[j]) <<< FRAC;
         end
         for (int lvl = 1; lvl < n; lvl++)
            for (int j = 0; j + lvl < n; j++) begin
               wx[j] = interp(wx[j], wx[j+1], t);
               wy[j] = interp(wy[j], wy[j+1], t);
            end
         dx = wx[0] - (longint'(seg_x[k]) <<< FRAC);
         dy = wy[0] - (longint'(seg_y[k]) <<< FRAC);
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         dv = bmd_pkg::DEV_WIDTH'((dx + dy) >> (FRAC - bmd_pkg::DEV_FRAC));
         if (dv > best_dev) begin
            best_dev = dv;
            best_k = k;
         end
      end
      m.id = seg_id[best_k];
      m.dev = best_dev;
      return m;
   endfunction

   initial begin
      errors = 0;
      seg_count = 0;
      wr_count = 0;
      rd_count = 0;
   end

   assign pending = wr_count - rd_count;

   always @(posedge clock) begin
      match_type got, want;
      if (reset) begin
         seg_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (seg_count < POINT_SLOTS) begin
               seg_x[seg_count] = req_x_coord;
               seg_y[seg_count] = req_y_coord;
               seg_id[seg_count] = req_point_id;
               seg_count = seg_count + 1;
            end
            if (req_last_point) begin
               expected_ring[wr_count % RING_DEPTH] = farthest_point(seg_count);
               wr_count = wr_count + 1;
               seg_count = 0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.id = rsp_max_point_id;
            got.dev = rsp_deviation;
            if (wr_count == rd_count) begin
               $error("unexpected response id=%0d deviation=%0d", got.id, got.dev);
               errors = errors + 1;
            end else begin
               want = expected_ring[rd_count % RING_DEPTH];
               rd_count = rd_count + 1;
               if (got.id !== want.id) begin
                  $error("max_point_id: expected %0d, got %0d", want.id, got.id);
                  errors = errors + 1;
               end
               if (got.dev !== want.dev) begin
                  $error("deviation: expected %0d, got %0d", want.dev, got.dev);
                  errors = errors + 1;
               end
            end
         end
      end
   end

endmodule

FILE: verif/bezier_max_deviation_test.sv
// Testbench top for the Bezier maximum-deviation block: makes clock, reset,
// request stimulus and response stalls. Depends on bezier_max_deviation,
// bezier_max_deviation_checker and bmd_pkg.
`timescale 1ns / 1ps

module bezier_max_deviation_test;

   localparam int MAX_GAP = 14;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [bmd_pkg::COORD_WIDTH-1:0] req_x_coord;
   logic signed [bmd_pkg::COORD_WIDTH-1:0] req_y_coord;
   logic [bmd_pkg::ID_WIDTH-1:0] req_point_id;
   logic req_last_point;
   logic rsp_valid;
   logic rsp_stall;
   logic [bmd_pkg::ID_WIDTH-1:0] rsp_max_point_id;
   logic [bmd_pkg::DEV_WIDTH-1:0] rsp_deviation;
   int errors;
   int pending;
   // while set, neither side idles: back-to-back stretches
   bit calm;

   bezier_max_deviation u_top (.*);

   bezier_max_deviation_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Hard stop: the one large run takes by far the longest, the rest far less.
   initial begin
      #40ms;
      $display("bezier_max_deviation_test failed");
      $finish;
   end

   // Send one request: idle a random gap, present it, hold until accepted.
   // Stall only moves at the rising edge, so look at it mid-cycle.
   task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [15:0] id, input logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_x_coord = x;
      req_y_coord = y;
      req_point_id = id;
      req_last_point = last;
      req_valid = 1'b1;
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // Send a run of n random points, the last one marked.
   task automatic send_random_run(input int n);
      for (int i = 0; i < n; i++)
         send_point(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
   endtask

   // Response side: stall for a random gap before taking each response.
   initial begin
      int w;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         w = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (w > 0) begin
            rsp_stall = 1'b1;
            repeat (w) @(negedge clock);
            rsp_stall = 1'b0;
         end
         while (!rsp_valid) @(negedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int sent;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_coord = '0;
      req_y_coord = '0;
      req_point_id = '0;
      req_last_point = 1'b0;
      calm = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single point run, extreme values
      send_point(-16'sd32768, 16'sd32767, 16'hFFFF, 1'b1);
      send_point(16'sd0, 16'sd0, 16'h0000, 1'b1);
      // two points at opposite corners: the curve hits both knots exactly
      send_point(-16'sd32768, -16'sd32768, 16'h0001, 1'b0);
      send_point(16'sd32767, 16'sd32767, 16'hFFFE, 1'b1);
      // identical points: every deviation zero, first id wins
      for (int i = 0; i < 4; i++) send_point(16'sd100, -16'sd7, 16'(i + 10), i == 3);
      // sharp spike in the middle, extreme swing
      send_point(-16'sd32768, 16'sd32767, 16'h1111, 1'b0);
      send_point(16'sd32767, -16'sd32768, 16'h2222, 1'b0);
      send_point(-16'sd32768, 16'sd32767, 16'h3333, 1'b1);
      // evenly stepped x, uneven y
      send_point(16'sd0, 16'sd0, 16'h0A0A, 1'b0);
      send_point(16'sd1, 16'sd1, 16'h0B0B, 1'b0);
      send_point(16'sd2, 16'sd9, 16'h0C0C, 1'b0);
      send_point(16'sd3, -16'sd5, 16'h0D0D, 1'b1);

      // store full: extra points are dropped, the last mark still closes
      calm = 1'b1;
      send_random_run(67);
      calm = 1'b0;

      // random runs, mostly short so the quadratic-per-point cost stays low
      sent = 0;
      while (sent < 205) begin
         calm = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0:       n = 1;
            9:       n = $urandom_range(9, 16);
            default: n = $urandom_range(2, 8);
         endcase
         send_random_run(n);
         sent += n;
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("bezier_max_deviation_test passed");
      else
         $display("bezier_max_deviation_test failed");
      $finish;
   end

endmodule
